/* rtl/core/lsp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the line-sensor pair error block.
package lsp_pkg;

   // Field widths.
   localparam int RAW_W  = 8;   // one raw sensor reading
   localparam int THR_W  = 7;   // threshold register
   localparam int OP_W   = 2;   // operation selector
   localparam int ERR_W  = 16;  // Q1.14 pair error
   localparam int DPCT_W = 15;  // reading offset times one hundred
   localparam int PCT_W  = 15;  // percentage in Q7.8
   localparam int SUM_W  = 16;  // sum of two percentages
   localparam int FRAC_W = 14;  // fraction bits of the pair error
   localparam int PCT_FRAC_W = 8;

   // Shared divider: numerator, divisor and quotient widths.
   localparam int NUM_W = 29;
   localparam int DEN_W = 16;
   localparam int QUO_W = 15;

   localparam logic [DPCT_W-1:0] PCT_SCALE  = DPCT_W'(100);
   localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(20);
   localparam logic [ERR_W-1:0]  ERR_POS_FS = 16'h4000;
   localparam logic [ERR_W-1:0]  ERR_NEG_FS = 16'hC000;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_SAMPLE     = 2'd0;
   localparam logic [OP_W-1:0] OP_PRESET_NEG = 2'd1;
   localparam logic [OP_W-1:0] OP_PRESET_POS = 2'd2;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic load;
      logic rotate;
   } cal_ctl_type;

   typedef struct packed {
      logic [RAW_W-1:0]  span;
      logic [DPCT_W-1:0] d_pct;
      logic              over;
   } cal_tap_type;

endpackage

/* rtl/core/lsp_div.sv */
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
module lsp_div (
   input  logic                clock,
   input  logic                reset,
   input  lsp_pkg::div_req_type req,
   output lsp_pkg::div_rsp_type rsp
);
   import lsp_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);
   localparam int HI_W  = NUM_W - QUO_W;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // The remainder always stays below the divisor, so one compare per bit suffices.
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};
   assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   assign quo_in = {quo_ff[QUO_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= {{(DEN_W - HI_W){1'b0}}, req.num[NUM_W-1:QUO_W]};
         quo_ff <= req.num[QUO_W-1:0];
         den_ff <= req.den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

/* rtl/core/lsp_cal.sv */
`timescale 1ns / 1ps
// Per-channel minimum and maximum tracking with a rotating read tap.
module lsp_cal #(
   parameter int CHANNELS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lsp_pkg::cal_ctl_type              ctl,
   input  logic [CHANNELS*lsp_pkg::RAW_W-1:0] raw_flat,
   input  logic [lsp_pkg::THR_W-1:0]         threshold,
   output lsp_pkg::cal_tap_type              tap
);
   import lsp_pkg::*;

   logic [RAW_W-1:0] raw_ff [CHANNELS];
   logic [RAW_W-1:0] min_ff [CHANNELS];
   logic [RAW_W-1:0] max_ff [CHANNELS];
   logic [RAW_W-1:0] d;
   logic [DPCT_W-1:0] thr_span;

   // Extremes are updated with the new reading first, then all three lines
   // rotate together so that each channel's data in turn sits at the tap.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            min_ff[i] <= '1;
            max_ff[i] <= '0;
         end
      end else if (ctl.load) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (raw_flat[i*RAW_W +: RAW_W] < min_ff[i]) begin
               min_ff[i] <= raw_flat[i*RAW_W +: RAW_W];
            end
            if (raw_flat[i*RAW_W +: RAW_W] > max_ff[i]) begin
               max_ff[i] <= raw_flat[i*RAW_W +: RAW_W];
            end
         end
      end else if (ctl.rotate) begin
         for (int i = 0; i < CHANNELS; i++) begin
            min_ff[i] <= min_ff[(i + 1) % CHANNELS];
            max_ff[i] <= max_ff[(i + 1) % CHANNELS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < CHANNELS; i++) begin
            raw_ff[i] <= raw_flat[i*RAW_W +: RAW_W];
         end
      end else if (ctl.rotate) begin
         for (int i = 0; i < CHANNELS; i++) begin
            raw_ff[i] <= raw_ff[(i + 1) % CHANNELS];
         end
      end
   end

   assign d         = raw_ff[0] - min_ff[0];
   assign tap.span  = max_ff[0] - min_ff[0];
   assign tap.d_pct = {{(DPCT_W - RAW_W){1'b0}}, d} * PCT_SCALE;
   assign thr_span  = {{(DPCT_W - THR_W){1'b0}}, threshold}
                    * {{(DPCT_W - RAW_W){1'b0}}, tap.span};
   assign tap.over  = tap.d_pct > thr_span;

endmodule

/* rtl/core/line_sensor_pair_error.sv */
`timescale 1ns / 1ps
// Top level: min/max calibrated line-sensor pair error with a shared serial divider.
// A sample frame runs through the single bit-serial divider, fifteen quotient bits per
// division: one division per channel and one per pair that is not held. A preset uses
// no division. One transaction is in flight at a time; tready returns the cycle after
// the result loads. Sync reset: min 255, max 0, signs negative, threshold 20.
module line_sensor_pair_error #(
   parameter int CHANNELS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // raw0 in bits 7:0, raw1 in bits 15:8, and so on up to the last channel.
   input  logic [CHANNELS*lsp_pkg::RAW_W-1:0]    req_tdata,
   // operation in bits 1:0.
   input  logic [lsp_pkg::OP_W-1:0]              req_tuser,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // err0 in bits 15:0, err1 in bits 31:16, and so on, one per channel pair.
   output logic [(CHANNELS/2)*lsp_pkg::ERR_W-1:0] rsp_tdata,
   // held_mask, one bit per channel pair from bit 0 up.
   output logic [CHANNELS/2-1:0]                 rsp_tuser,
   // Threshold register write port.
   input  logic                                  csr_we,
   input  logic [lsp_pkg::THR_W-1:0]             csr_wdata
);
   import lsp_pkg::*;

   localparam int PAIRS  = CHANNELS / 2;
   localparam int CH_W   = $clog2(CHANNELS);
   localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_CH_START  = 6'b000010,
      ST_CH_WAIT   = 6'b000100,
      ST_PAIR      = 6'b001000,
      ST_PAIR_WAIT = 6'b010000,
      ST_DONE      = 6'b100000
   } state_type;

   state_type          state_ff;
   logic [CH_W-1:0]    ch_cnt_ff;
   logic [PAIR_W-1:0]  pair_cnt_ff;
   logic [THR_W-1:0]   thr_ff;
   logic               err_pos_ff [PAIRS];

   // Working storage: percentages and exceed flags shift in per channel and
   // shift out two at a time per pair; errors shift in per pair.
   logic [PCT_W-1:0]   pct_ff  [CHANNELS];
   logic               ov_ff   [CHANNELS];
   logic [ERR_W-1:0]   err_ff  [PAIRS];
   logic               held_ff [PAIRS];
   logic               neg_ff;

   logic                     rsp_valid_ff;
   logic [PAIRS*ERR_W-1:0]   rsp_data_ff;
   logic [PAIRS-1:0]         rsp_user_ff;

   cal_ctl_type  cal_ctl;
   cal_tap_type  tap;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   logic               accept;
   logic               preset;
   logic               preset_pos;
   logic               out_free;
   logic [NUM_W-1:0]   ch_num;
   logic [PCT_W-1:0]   ch_pct;
   logic [PCT_W-1:0]   pa;
   logic [PCT_W-1:0]   pb;
   logic [SUM_W-1:0]   pair_sum;
   logic               pair_neg;
   logic [PCT_W-1:0]   pair_diff;
   logic [NUM_W-1:0]   pair_num;
   logic               pair_go;
   logic               pair_step;
   logic [ERR_W-1:0]   div_mag;
   logic [ERR_W-1:0]   div_err;
   logic               div_pos;
   logic [ERR_W-1:0]   step_err;
   logic               step_pos;
   logic               step_held;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign preset     = (req_tuser == OP_PRESET_NEG) || (req_tuser == OP_PRESET_POS);
   assign preset_pos = (req_tuser == OP_PRESET_POS);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign cal_ctl.load   = accept && !preset;
   assign cal_ctl.rotate = (state_ff == ST_CH_WAIT) && div_rsp.done;

   lsp_cal #(
      .CHANNELS (CHANNELS)
   ) u_cal (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cal_ctl),
      .raw_flat  (req_tdata),
      .threshold (thr_ff),
      .tap       (tap)
   );

   // Channel percentage: floor(d * 25600 / span), numerator is (d * 100) << 8.
   assign ch_num = {{(NUM_W - DPCT_W - PCT_FRAC_W){1'b0}}, tap.d_pct, {PCT_FRAC_W{1'b0}}};
   // A zero span gives a zero percentage, whatever the divider returns.
   assign ch_pct = (tap.span == '0) ? '0 : div_rsp.quot;

   // Pair error: (|pb - pa| * 16384 + sum / 2) / sum, sign applied afterwards.
   assign pa        = pct_ff[0];
   assign pb        = pct_ff[1];
   assign pair_sum  = {1'b0, pa} + {1'b0, pb};
   assign pair_neg  = pb < pa;
   assign pair_diff = pair_neg ? (pa - pb) : (pb - pa);
   assign pair_num  = {pair_diff, {FRAC_W{1'b0}}}
                    + {{(NUM_W - SUM_W + 1){1'b0}}, pair_sum[SUM_W-1:1]};
   assign pair_go   = (ov_ff[0] || ov_ff[1]) && (pair_sum != '0);

   always_comb begin
      div_req.start = (state_ff == ST_CH_START) || ((state_ff == ST_PAIR) && pair_go);
      if (state_ff == ST_PAIR) begin
         div_req.num = pair_num;
         div_req.den = pair_sum;
      end else begin
         div_req.num = ch_num;
         div_req.den = {{(DEN_W - RAW_W){1'b0}}, tap.span};
      end
   end

   lsp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // A finished pair: either the divider result or full scale at the old sign.
   assign div_mag   = {1'b0, div_rsp.quot};
   assign div_err   = neg_ff ? (ERR_W'(0) - div_mag) : div_mag;
   assign div_pos   = !neg_ff && (div_rsp.quot != '0);
   assign step_held = (state_ff == ST_PAIR);
   assign step_err  = step_held ? (err_pos_ff[0] ? ERR_POS_FS : ERR_NEG_FS) : div_err;
   assign step_pos  = step_held ? err_pos_ff[0] : div_pos;
   assign pair_step = ((state_ff == ST_PAIR) && !pair_go)
                   || ((state_ff == ST_PAIR_WAIT) && div_rsp.done);

   // Sequencer and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_cnt_ff    <= '0;
         pair_cnt_ff  <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < PAIRS; p++) begin
            err_pos_ff[p] <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         // The sign line rotates once per pair so the current pair's sign is at the tap.
         if (accept && preset) begin
            for (int p = 0; p < PAIRS; p++) begin
               err_pos_ff[p] <= preset_pos;
            end
         end else if (pair_step) begin
            for (int p = 0; p < PAIRS - 1; p++) begin
               err_pos_ff[p] <= err_pos_ff[p+1];
            end
            err_pos_ff[PAIRS-1] <= step_pos;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ch_cnt_ff <= '0;
                  state_ff  <= preset ? ST_DONE : ST_CH_START;
               end
            end
            ST_CH_START: begin
               state_ff <= ST_CH_WAIT;
            end
            ST_CH_WAIT: begin
               if (div_rsp.done) begin
                  if (ch_cnt_ff == CH_W'(CHANNELS - 1)) begin
                     pair_cnt_ff <= '0;
                     state_ff    <= ST_PAIR;
                  end else begin
                     ch_cnt_ff <= ch_cnt_ff + CH_W'(1);
                     state_ff  <= ST_CH_START;
                  end
               end
            end
            ST_PAIR, ST_PAIR_WAIT: begin
               if ((state_ff == ST_PAIR) && pair_go) begin
                  state_ff <= ST_PAIR_WAIT;
               end else if (pair_step) begin
                  if (pair_cnt_ff == PAIR_W'(PAIRS - 1)) begin
                     state_ff <= ST_DONE;
                  end else begin
                     pair_cnt_ff <= pair_cnt_ff + PAIR_W'(1);
                     state_ff    <= ST_PAIR;
                  end
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Datapath shift lines and the result register.
   always_ff @(posedge clock) begin
      if (cal_ctl.rotate) begin
         for (int i = 0; i < CHANNELS - 1; i++) begin
            pct_ff[i] <= pct_ff[i+1];
            ov_ff[i]  <= ov_ff[i+1];
         end
         pct_ff[CHANNELS-1] <= ch_pct;
         ov_ff[CHANNELS-1]  <= tap.over;
      end else if (pair_step) begin
         for (int i = 0; i < CHANNELS - 2; i++) begin
            pct_ff[i] <= pct_ff[i+2];
            ov_ff[i]  <= ov_ff[i+2];
         end
      end

      if ((state_ff == ST_PAIR) && pair_go) begin
         neg_ff <= pair_neg;
      end

      if (accept && preset) begin
         for (int p = 0; p < PAIRS; p++) begin
            err_ff[p]  <= preset_pos ? ERR_POS_FS : ERR_NEG_FS;
            held_ff[p] <= 1'b0;
         end
      end else if (pair_step) begin
         for (int p = 0; p < PAIRS - 1; p++) begin
            err_ff[p]  <= err_ff[p+1];
            held_ff[p] <= held_ff[p+1];
         end
         err_ff[PAIRS-1]  <= step_err;
         held_ff[PAIRS-1] <= step_held;
      end

      if ((state_ff == ST_DONE) && out_free) begin
         for (int p = 0; p < PAIRS; p++) begin
            rsp_data_ff[p*ERR_W +: ERR_W] <= err_ff[p];
            rsp_user_ff[p]                <= held_ff[p];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* dv/tb_line_sensor_pair_error.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the line-sensor pair error block: directed and random frames.
module tb_line_sensor_pair_error;
   import lsp_pkg::*;

   localparam int CHANNELS      = 8;
   localparam int PAIRS         = CHANNELS / 2;
   localparam int FULL_SCALE    = 16384;
   localparam int PHASES        = 8;
   localparam int RANDOM_FRAMES = 1750;
   // The tail wait is long enough for one more sample frame.
   localparam int DRAIN_CYCLES  = 250;
   // The slowest run is about 1770 transactions plus random gaps, and this limit is several
   // times its worst case.
   localparam int CYCLE_LIMIT   = 1_500_000;
   // The block treats the spare operation code as a sample frame.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Scoreboard: keeps its own copy of the calibration state and the threshold, works
   // out the response of every accepted request, and checks responses in order.
   class pair_error_scoreboard;
      logic [THR_W-1:0]       threshold;
      logic [RAW_W-1:0]       chan_hi [CHANNELS];
      logic [RAW_W-1:0]       chan_lo [CHANNELS];
      bit                     last_positive [PAIRS];
      logic [PAIRS*ERR_W-1:0] expected_errs_q [$];
      logic [PAIRS-1:0]       expected_held_q [$];
      int                     mismatches;
      int                     checked;
      int                     frames;
      int                     presets;
      int                     held_pairs;
      int                     live_pairs;

      function new();
         threshold = THR_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            chan_hi[i] = '0;
            chan_lo[i] = '1;
         end
         for (int p = 0; p < PAIRS; p++) begin
            last_positive[p] = 1'b0;
         end
         mismatches = 0;
         checked    = 0;
         frames     = 0;
         presets    = 0;
         held_pairs = 0;
         live_pairs = 0;
      endfunction

      function int pending();
         return expected_errs_q.size();
      endfunction

      function void log_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endfunction

      function void accept_request(logic [OP_W-1:0] op, logic [CHANNELS*RAW_W-1:0] frame);
         int unsigned            pct [CHANNELS];
         bit                     over [CHANNELS];
         logic [PAIRS*ERR_W-1:0] errs;
         logic [PAIRS-1:0]       held;
         logic [RAW_W-1:0]       raw;
         int unsigned            d;
         int unsigned            span;
         int unsigned            pa;
         int unsigned            pb;
         int unsigned            sum;
         int unsigned            diff;
         int unsigned            mag;
         int                     e;
         errs = '0;
         held = '0;
         if (op == OP_PRESET_NEG || op == OP_PRESET_POS) begin
            // Presets leave the extremes alone and only force the signs.
            presets++;
            for (int p = 0; p < PAIRS; p++) begin
               last_positive[p] = (op == OP_PRESET_POS);
               errs[p*ERR_W +: ERR_W] = last_positive[p] ? ERR_POS_FS : ERR_NEG_FS;
            end
         end else begin
            frames++;
            for (int i = 0; i < CHANNELS; i++) begin
               raw = frame[i*RAW_W +: RAW_W];
               if (raw > chan_hi[i]) chan_hi[i] = raw;
               if (raw < chan_lo[i]) chan_lo[i] = raw;
               d    = raw - chan_lo[i];
               span = chan_hi[i] - chan_lo[i];
               if (span == 0) begin
                  pct[i]  = 0;
                  over[i] = 1'b0;
               end else begin
                  pct[i]  = d * 25600 / span;
                  over[i] = (d * 100) > (threshold * span);
               end
            end
            for (int p = 0; p < PAIRS; p++) begin
               pa  = pct[2*p];
               pb  = pct[2*p+1];
               sum = pa + pb;
               if ((over[2*p] || over[2*p+1]) && sum != 0) begin
                  diff = (pb >= pa) ? pb - pa : pa - pb;
                  mag  = (diff * FULL_SCALE + sum / 2) / sum;
                  e    = (pb >= pa) ? int'(mag) : -int'(mag);
                  last_positive[p] = (e > 0);
                  live_pairs++;
               end else begin
                  e = last_positive[p] ? FULL_SCALE : -FULL_SCALE;
                  held[p] = 1'b1;
                  held_pairs++;
               end
               errs[p*ERR_W +: ERR_W] = ERR_W'(e);
            end
         end
         expected_errs_q = {expected_errs_q, errs};
         expected_held_q = {expected_held_q, held};
      endfunction

      function void check_response(logic [PAIRS*ERR_W-1:0] errs, logic [PAIRS-1:0] held);
         logic [PAIRS*ERR_W-1:0] exp_errs;
         logic [PAIRS-1:0]       exp_held;
         if (expected_errs_q.size() == 0) begin
            log_mismatch($sformatf("response with nothing outstanding, errs %h held %b",
                                   errs, held));
            return;
         end
         exp_errs = expected_errs_q.pop_front();
         exp_held = expected_held_q.pop_front();
         checked++;
         for (int p = 0; p < PAIRS; p++) begin
            if (errs[p*ERR_W +: ERR_W] !== exp_errs[p*ERR_W +: ERR_W]) begin
               log_mismatch($sformatf("response %0d err%0d expected %0d actual %0d",
                                      checked, p, $signed(exp_errs[p*ERR_W +: ERR_W]),
                                      $signed(errs[p*ERR_W +: ERR_W])));
            end
         end
         if (held !== exp_held) begin
            log_mismatch($sformatf("response %0d held_mask expected %b actual %b",
                                   checked, exp_held, held));
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [CHANNELS*RAW_W-1:0]    req_tdata;   // raw0 in bits 7:0 up to raw7 in bits 63:56
   logic [OP_W-1:0]              req_tuser;   // operation in bits 1:0
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [PAIRS*ERR_W-1:0]       rsp_tdata;   // err0 in bits 15:0 up to err3 in bits 63:48
   logic [PAIRS-1:0]             rsp_tuser;   // held_mask, pair 0 in bit 0
   logic                         csr_we;
   logic [THR_W-1:0]             csr_wdata;

   pair_error_scoreboard sb;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int cycle_count    = 0;

   line_sensor_pair_error #(.CHANNELS(CHANNELS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Presents one request transaction and returns at the edge that accepts it. The valid
   // is only lowered here when a gap is rolled, so back-to-back transactions keep it high
   // and it never gets two assignments in one time step.
   task automatic send_item(input logic [OP_W-1:0] op,
                            input logic [CHANNELS*RAW_W-1:0] frame);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= frame;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      sb.accept_request(op, frame);
   endtask

   // The threshold may only change while the block is idle, so callers drain first.
   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.threshold = value;
      csr_we <= 1'b0;
   endtask

   // Response side: checks every accepted transaction against the oldest expectation and
   // rolls the ready for the next cycle. Outputs are read right after the edge, before any
   // of this edge's updates land, so the values seen are the ones the block presented.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata, rsp_tuser);
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, sb.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [CHANNELS*RAW_W-1:0] frame;
      logic [OP_W-1:0]           op;
      logic [THR_W-1:0]          thr;
      int                        roll;
      int                        thresholds_used;
      sb = new();
      thresholds_used = 1;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_SAMPLE;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset threshold and with no pacing gaps.
      // A first frame gives every channel a zero span: all pairs held, negative.
      send_item(OP_SAMPLE, {CHANNELS{8'd128}});
      // After a positive preset the held value flips to plus full scale.
      send_item(OP_PRESET_POS, {CHANNELS{8'hA5}});
      send_item(OP_SAMPLE, {CHANNELS{8'd128}});
      // The spare operation code behaves as a sample frame.
      send_item(OP_UNUSED, {CHANNELS{8'd128}});
      // Narrow spans around the first reading stress the rounding of small divisions.
      for (int n = 0; n < 4; n++) begin
         for (int i = 0; i < CHANNELS; i++) begin
            frame[i*RAW_W +: RAW_W] = 8'd120 + RAW_W'($urandom_range(15));
         end
         send_item(OP_SAMPLE, frame);
      end
      // Open every span to the full range: odd channel at the top, then the even one.
      send_item(OP_SAMPLE, {PAIRS{8'd255, 8'd0}});
      send_item(OP_SAMPLE, {PAIRS{8'd0, 8'd255}});
      // Both members at full percentage give a zero error, which counts as negative.
      send_item(OP_SAMPLE, {CHANNELS{8'd255}});
      // Both at zero percentage: nobody exceeds, so every pair is held.
      send_item(OP_SAMPLE, {CHANNELS{8'd0}});
      send_item(OP_PRESET_NEG, {CHANNELS{8'h5A}});
      send_item(OP_SAMPLE, {CHANNELS{8'd128}});
      // Readings exactly on the 20 percent boundary (51 of 255) do not exceed; 52 does.
      send_item(OP_SAMPLE, {8'd51, 8'd0, 8'd52, 8'd51, 8'd0, 8'd52, 8'd51, 8'd51});
      send_item(OP_PRESET_POS, '1);
      send_item(OP_SAMPLE, {8'd3, 8'd4, 8'd255, 8'd1, 8'd60, 8'd200, 8'd250, 8'd10});
      send_item(OP_SAMPLE, {8'd1, 8'd2, 8'd100, 8'd101, 8'd127, 8'd128, 8'd254, 8'd255});

      // Random part: each phase has its own threshold and handshake pacing. Thresholds
      // include both ends of the legal range and values above 100, where every pair holds.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            case (phase)
               1:       thr = 7'd0;
               2:       thr = 7'd100;
               3:       thr = 7'd127;
               4:       thr = 7'd1;
               5:       thr = 7'd50;
               6:       thr = THR_W'($urandom_range(99, 2));
               default: thr = 7'd101;
            endcase
            write_threshold(thr);
            thresholds_used++;
         end
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 52;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 52;
            end
            default: begin
               send_idle_pct  = 37;
               recv_stall_pct = 37;
            end
         endcase
         for (int n = 0; n < RANDOM_FRAMES / PHASES; n++) begin
            roll = $urandom_range(99);
            if (roll < 4) op = OP_PRESET_NEG;
            else if (roll < 8) op = OP_PRESET_POS;
            else if (roll < 11) op = OP_UNUSED;
            else op = OP_SAMPLE;
            // Readings cluster near both ends of the span so that pairs fall on either
            // side of the threshold, with a uniform share in between.
            for (int i = 0; i < CHANNELS; i++) begin
               roll = $urandom_range(99);
               if (roll < 35) frame[i*RAW_W +: RAW_W] = RAW_W'($urandom_range(30));
               else if (roll < 65) frame[i*RAW_W +: RAW_W] = RAW_W'($urandom_range(255, 200));
               else frame[i*RAW_W +: RAW_W] = RAW_W'($urandom_range(255));
            end
            send_item(op, frame);
         end
         // Drain before the next threshold write; the block is idle once all are back.
         req_tvalid <= 1'b0;
         do @(posedge clock); while (sb.pending() > 0);
      end

      // Leave time for any stray response to show up before judging the run.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() > 0) begin
         $display("%0d expected responses never arrived", sb.pending());
      end
      $display("Covered %0d sample frames and %0d presets over %0d threshold settings",
               sb.frames, sb.presets, thresholds_used);
      $display("and four pacing modes: %0d pair errors proportional, %0d held; %0d mismatches.",
               sb.live_pairs, sb.held_pairs, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
